FILE: src/pidc_pkg.sv
package pidc_pkg;

  localparam int DataW = 32;
  localparam int AccW  = 64;
  localparam int MulAW = 66;
  localparam int MulPW = 67;
  localparam int DivNW = 65;

  typedef enum logic [2:0] {
    REG_DIRECT_GAIN = 3'd0,
    REG_ACCUM_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_FILTER_KEEP = 3'd3,
    REG_ACCUM_LIMIT = 3'd4,
    REG_STEP_LIMIT  = 3'd5,
    REG_DRIVE_MIN   = 3'd6,
    REG_DRIVE_MAX   = 3'd7
  } reg_idx_e;

  localparam logic signed [AccW-1:0] SatMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] SatMin = {1'b1, {(AccW-1){1'b0}}};

  function automatic logic signed [AccW-1:0] sat_add(input logic signed [AccW-1:0] a,
                                                      input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) return s[AccW] ? SatMin : SatMax;
    return s[AccW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] sat_wide(input logic signed [MulPW-1:0] x);
    if (x[MulPW-1:AccW-1] != {(MulPW-AccW+1){x[AccW-1]}}) begin
      return x[MulPW-1] ? SatMin : SatMax;
    end
    return x[AccW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] clip_sym(input logic signed [AccW-1:0] x,
                                                       input logic [AccW-2:0] lim);
    logic signed [AccW-1:0] l;
    l = {1'b0, lim};
    if (x > l) return l;
    if (x < -l) return -l;
    return x;
  endfunction

endpackage

FILE: src/pidc_mul.sv
// Serial signed-by-unsigned multiplier: one multiplier bit per cycle,
// giving floor(a * b / 2^32). The low bits are dropped as they shift out.
module pidc_mul import pidc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [MulAW-1:0] a_i,
  input  logic [DataW-1:0]        b_i,
  output logic                    done_o,
  output logic signed [MulPW-1:0] p_o
);

  logic signed [MulPW-1:0] acc_q;
  logic signed [MulAW-1:0] a_q;
  logic [DataW-1:0]        b_q;
  logic [5:0]              cnt_q;
  logic                    done_q;
  logic signed [MulPW:0]   sum;

  assign sum = {acc_q[MulPW-1], acc_q} +
               (b_q[0] ? {{(MulPW+1-MulAW){a_q[MulAW-1]}}, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 6'(DataW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 6'd1;
        done_q <= (cnt_q == 6'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      a_q   <= a_i;
      b_q   <= b_i;
    end else if (cnt_q != '0) begin
      acc_q <= sum[MulPW:1];
      b_q   <= b_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

FILE: src/pidc_div.sv
// Restoring divider, one quotient bit per cycle.
module pidc_div import pidc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [DivNW-1:0] quo_o
);

  logic [DataW-1:0] rem_q;
  logic [DataW-1:0] den_q;
  logic [DivNW-1:0] quo_q;
  logic [6:0]       cnt_q;
  logic             done_q;
  logic [DataW:0]   trial;
  logic             ge;
  logic [DataW:0]   diff;

  assign trial = {rem_q, quo_q[DivNW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 7'(DivNW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - 7'd1;
        done_q <= (cnt_q == 7'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? diff[DataW-1:0] : trial[DataW-1:0];
      quo_q <= {quo_q[DivNW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/pid_controller_fixed_point_core.sv
// Channel  Handshake                Payload
// in       in_valid_i / in_ready_o  kind_i, error_sample_i, preset_drive_i
// out      out_valid_o / out_ready_i drive_o
// cfg      psel/penable/pwrite      paddr, pwdata, prdata (pready tied high)
//
// Each serial multiply runs on the shared multiplier. An update word runs three
// to six of them (two filter steps only with a nonzero retention, a second
// accumulator product only when the accumulator grows), plus a decide state
// and an output state. A preset word runs one multiply and a serial divide, or
// only the multiply with a zero accumulator gain. A new word is taken in the
// cycle after the previous one is finished. The result register lets the next
// word start while a drive value waits; the block stalls at the end only if
// the result is still held. Reset clears the state and loads the register
// defaults.
module pid_controller_fixed_point_core import pidc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    kind_i,
  input  logic signed [DataW-1:0] error_sample_i,
  input  logic signed [DataW-1:0] preset_drive_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] drive_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [5:0]              paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIRECT, ST_DIV, ST_FILT1, ST_FILT2,
    ST_DERIV, ST_CURR, ST_DECIDE, ST_CURR2, ST_FINAL
  } state_e;

  state_e state_q;

  logic [DataW-1:0]        kp_q, ki_q, kd_q, keep_q;
  logic [AccW-2:0]         acc_lim_q;
  logic [DataW-2:0]        step_lim_q;
  logic signed [DataW-1:0] dmin_q, dmax_q;

  logic signed [AccW-1:0]  acc_q, df_q;
  logic signed [DataW-1:0] prev_q, err_q, pre_q;
  logic                    kind_q;
  logic signed [AccW-1:0]  direct_q, t1_q, base_q, curr_q;
  logic                    pneg_q;
  logic [DataW:0]          pmag_q;
  logic                    mul_busy_q, div_busy_q;
  logic                    out_valid_q;
  logic signed [DataW-1:0] drive_q;

  logic                    mul_start, mul_done;
  logic signed [MulAW-1:0] mul_a;
  logic [DataW-1:0]        mul_b;
  logic signed [MulPW-1:0] mul_p;
  logic                    div_start, div_done;
  logic [DivNW-1:0]        div_q;

  logic signed [DataW:0]   diff;
  logic signed [33:0]      pd;
  logic signed [AccW-1:0]  trial, step, acc_new, total, drive_d;
  logic                    grow;
  logic [AccW-2:0]         div_mag;
  logic                    cfg_wr;

  assign diff = {err_q[DataW-1], err_q} - {prev_q[DataW-1], prev_q};
  assign pd   = {{2{pre_q[DataW-1]}}, pre_q} - mul_p[33:0];

  always_comb begin
    unique case (state_q)
      ST_FILT1: begin
        mul_a = {{2{df_q[AccW-1]}}, df_q};
        mul_b = keep_q;
      end
      ST_FILT2: begin
        mul_a = {diff[DataW], diff, {DataW{1'b0}}};
        mul_b = -keep_q;
      end
      ST_DERIV: begin
        mul_a = {{(MulAW-DataW){df_q[AccW-1]}}, df_q[AccW-1:DataW]};
        mul_b = kd_q;
      end
      ST_CURR, ST_CURR2: begin
        mul_a = {{2{acc_q[AccW-1]}}, acc_q};
        mul_b = ki_q;
      end
      default: begin
        mul_a = {{(MulAW-DataW){err_q[DataW-1]}}, err_q};
        mul_b = kp_q;
      end
    endcase
  end

  assign mul_start = !mul_busy_q && (state_q == ST_DIRECT || state_q == ST_FILT1 ||
                     state_q == ST_FILT2 || state_q == ST_DERIV ||
                     state_q == ST_CURR || state_q == ST_CURR2);
  assign div_start = !div_busy_q && state_q == ST_DIV;

  pidc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  pidc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({pmag_q, {DataW{1'b0}}}),
    .den_i   (ki_q),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  assign div_mag = (div_q > {2'b00, acc_lim_q}) ? acc_lim_q : div_q[AccW-2:0];

  always_comb begin
    trial = sat_add(base_q, curr_q);
    grow  = (err_q[DataW-1] && trial > 64'(dmin_q)) ||
            (!err_q[DataW-1] && err_q != '0 && trial < 64'(dmax_q));
    step  = clip_sym(64'(err_q), {32'b0, step_lim_q});
    acc_new = clip_sym(sat_add(acc_q, step), acc_lim_q);
    total = sat_add(base_q, curr_q);
    if (total < 64'(dmin_q)) begin
      drive_d = 64'(dmin_q);
    end else if (total > 64'(dmax_q)) begin
      drive_d = 64'(dmax_q);
    end else begin
      drive_d = total;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mul_busy_q  <= 1'b0;
      div_busy_q  <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      df_q        <= '0;
      prev_q      <= '0;
    end else begin
      // The output step refills the result register itself.
      if (out_valid_q && out_ready_i && state_q != ST_FINAL) out_valid_q <= 1'b0;
      if (mul_start) mul_busy_q <= 1'b1;
      if (mul_done) mul_busy_q <= 1'b0;
      if (div_start) div_busy_q <= 1'b1;
      if (div_done) div_busy_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_DIRECT;
        end
        ST_DIRECT: begin
          if (mul_done) begin
            direct_q <= mul_p[AccW-1:0];
            if (kind_q) begin
              pneg_q <= pd[33];
              pmag_q <= pd[33] ? 33'(-pd) : pd[DataW:0];
              if (ki_q == '0) begin
                if (pd == '0) acc_q <= '0;
                else acc_q <= pd[33] ? -{1'b0, acc_lim_q} : {1'b0, acc_lim_q};
                state_q <= ST_IDLE;
              end else begin
                state_q <= ST_DIV;
              end
            end else if (keep_q != '0) begin
              state_q <= ST_FILT1;
            end else begin
              df_q    <= sat_wide({{2{diff[DataW]}}, diff, {DataW{1'b0}}});
              state_q <= ST_DERIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            acc_q   <= pneg_q ? -{1'b0, div_mag} : {1'b0, div_mag};
            state_q <= ST_IDLE;
          end
        end
        ST_FILT1: begin
          if (mul_done) begin
            t1_q    <= mul_p[AccW-1:0];
            state_q <= ST_FILT2;
          end
        end
        ST_FILT2: begin
          if (mul_done) begin
            df_q    <= sat_add(t1_q, sat_wide(mul_p));
            state_q <= ST_DERIV;
          end
        end
        ST_DERIV: begin
          if (mul_done) begin
            base_q  <= sat_add(direct_q, mul_p[AccW-1:0]);
            state_q <= ST_CURR;
          end
        end
        ST_CURR: begin
          if (mul_done) begin
            curr_q  <= mul_p[AccW-1:0];
            state_q <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          prev_q <= err_q;
          if (grow) begin
            acc_q   <= acc_new;
            state_q <= ST_CURR2;
          end else begin
            state_q <= ST_FINAL;
          end
        end
        ST_CURR2: begin
          if (mul_done) begin
            curr_q  <= mul_p[AccW-1:0];
            state_q <= ST_FINAL;
          end
        end
        ST_FINAL: begin
          if (!out_valid_q || out_ready_i) begin
            drive_q     <= drive_d[DataW-1:0];
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      err_q  <= error_sample_i;
      pre_q  <= preset_drive_i;
    end
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;

  // Register file.
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      keep_q     <= '0;
      acc_lim_q  <= '0;
      step_lim_q <= '0;
      dmin_q     <= {1'b1, {(DataW-1){1'b0}}};
      dmax_q     <= {1'b0, {(DataW-1){1'b1}}};
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[5:3]))
        REG_DIRECT_GAIN: kp_q       <= pwdata[DataW-1:0];
        REG_ACCUM_GAIN:  ki_q       <= pwdata[DataW-1:0];
        REG_DERIV_GAIN:  kd_q       <= pwdata[DataW-1:0];
        REG_FILTER_KEEP: keep_q     <= pwdata[DataW-1:0];
        REG_ACCUM_LIMIT: acc_lim_q  <= pwdata[AccW-2:0];
        REG_STEP_LIMIT:  step_lim_q <= pwdata[DataW-2:0];
        REG_DRIVE_MIN:   dmin_q     <= pwdata[DataW-1:0];
        REG_DRIVE_MAX:   dmax_q     <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[5:3]))
      REG_DIRECT_GAIN: prdata = 64'(kp_q);
      REG_ACCUM_GAIN:  prdata = 64'(ki_q);
      REG_DERIV_GAIN:  prdata = 64'(kd_q);
      REG_FILTER_KEEP: prdata = 64'(keep_q);
      REG_ACCUM_LIMIT: prdata = 64'(acc_lim_q);
      REG_STEP_LIMIT:  prdata = 64'(step_lim_q);
      REG_DRIVE_MIN:   prdata = 64'(dmin_q);
      REG_DRIVE_MAX:   prdata = 64'(dmax_q);
      default:         prdata = '0;
    endcase
  end

  a_mul_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == ST_DIRECT || state_q == ST_FILT1 || state_q == ST_FILT2 ||
                  state_q == ST_DERIV || state_q == ST_CURR || state_q == ST_CURR2))
    else $error("multiplier finished outside a multiply step");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside the preset divide");

  a_final_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL && out_valid_q && !out_ready_i) |=> state_q == ST_FINAL)
    else $error("result dropped while output held");

endmodule
